[src/ir_pulse_width_byte_transmitter_assert.svh]
// ----------------------------------------------------------------------------
// ir pulse width transmitter assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_BYTE_TRANSMITTER_ASSERT_SVH
`define IR_PULSE_WIDTH_BYTE_TRANSMITTER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define IRPW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("irpw assertion failed");

// expression must never be true outside reset
`define IRPW_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("irpw forbidden condition seen");

`else

`define IRPW_ASSERT(label, clk, rst, prop)
`define IRPW_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[src/irpw_pkg.sv]
// ----------------------------------------------------------------------------
// irpw_pkg
// shared types, constants and helpers of the ir pulse width transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package irpw_pkg;

   localparam int BITS_PER_FRAME = 8;
   localparam int BITS_W         = $clog2(BITS_PER_FRAME + 1);
   localparam int TICK_W         = 16;
   localparam int BYTE_W         = 8;
   localparam int ADDR_W         = 5;
   localparam int DATA_W         = 32;

   localparam logic [TICK_W-1:0] LEAD_MARK_RESET  = 16'd3000;
   localparam logic [TICK_W-1:0] LEAD_SPACE_RESET = 16'd1000;
   localparam logic [TICK_W-1:0] SHORT_RESET      = 16'd800;
   localparam logic [TICK_W-1:0] LONG_RESET       = 16'd1600;
   localparam logic [TICK_W-1:0] STOP_MARK_RESET  = 16'd500;

   typedef enum logic [2:0] {
      REG_LEAD_MARK  = 3'd0,
      REG_LEAD_SPACE = 3'd1,
      REG_SHORT      = 3'd2,
      REG_LONG       = 3'd3,
      REG_STOP_MARK  = 3'd4
   } reg_index_type;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_SEND = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_LEADM = 3'd1,
      PH_LEADS = 3'd2,
      PH_BITM  = 3'd3,
      PH_BITS  = 3'd4,
      PH_STOP  = 3'd5
   } phase_type;

   typedef struct packed {
      logic              operation;
      logic [BYTE_W-1:0] code_byte;
   } req_word_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } rsp_word_type;

   // classified word handed from front to back
   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] code_byte;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_port_type;

   typedef struct packed {
      logic [TICK_W-1:0] lead_mark_ticks;
      logic [TICK_W-1:0] lead_space_ticks;
      logic [TICK_W-1:0] short_ticks;
      logic [TICK_W-1:0] long_ticks;
      logic [TICK_W-1:0] stop_mark_ticks;
   } cfg_type;

   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] d);
      at_least_one = (d == '0) ? TICK_W'(1) : d;
   endfunction

endpackage

`default_nettype wire

[src/irpw_csr.sv]
// ----------------------------------------------------------------------------
// irpw_csr
// apb register file holding the segment durations
// ----------------------------------------------------------------------------
`default_nettype none

module irpw_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [irpw_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [irpw_pkg::DATA_W-1:0]  pwdata,
   output logic      [irpw_pkg::DATA_W-1:0]  prdata,
   output logic                              pready,
   output irpw_pkg::cfg_type                 cfg
);

   irpw_pkg::cfg_type      cfg_ff;
   irpw_pkg::cfg_type      cfg_in;
   irpw_pkg::reg_index_type idx;
   logic                   wr_en;
   logic [irpw_pkg::TICK_W-1:0] wval;

   assign idx    = irpw_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en  = psel & penable & pwrite;
   assign wval   = pwdata[irpw_pkg::TICK_W-1:0];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            irpw_pkg::REG_LEAD_MARK:  cfg_in.lead_mark_ticks  = wval;
            irpw_pkg::REG_LEAD_SPACE: cfg_in.lead_space_ticks = wval;
            irpw_pkg::REG_SHORT:      cfg_in.short_ticks      = wval;
            irpw_pkg::REG_LONG:       cfg_in.long_ticks       = wval;
            irpw_pkg::REG_STOP_MARK:  cfg_in.stop_mark_ticks  = wval;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (idx)
         irpw_pkg::REG_LEAD_MARK:  prdata = {16'd0, cfg_ff.lead_mark_ticks};
         irpw_pkg::REG_LEAD_SPACE: prdata = {16'd0, cfg_ff.lead_space_ticks};
         irpw_pkg::REG_SHORT:      prdata = {16'd0, cfg_ff.short_ticks};
         irpw_pkg::REG_LONG:       prdata = {16'd0, cfg_ff.long_ticks};
         irpw_pkg::REG_STOP_MARK:  prdata = {16'd0, cfg_ff.stop_mark_ticks};
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lead_mark_ticks  <= irpw_pkg::LEAD_MARK_RESET;
         cfg_ff.lead_space_ticks <= irpw_pkg::LEAD_SPACE_RESET;
         cfg_ff.short_ticks      <= irpw_pkg::SHORT_RESET;
         cfg_ff.long_ticks       <= irpw_pkg::LONG_RESET;
         cfg_ff.stop_mark_ticks  <= irpw_pkg::STOP_MARK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[src/irpw_front.sv]
// ----------------------------------------------------------------------------
// irpw_front
// accepts request words, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
`default_nettype none

module irpw_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire irpw_pkg::req_word_type req_data,
   output irpw_pkg::cmd_port_type      cmd_port,
   input  wire logic                   cmd_pop
);

   // two entry queue
   irpw_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;
   irpw_pkg::cmd_type cmd_new;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid & req_ready;
   assign pop       = cmd_pop & (count_ff != 2'd0);

   always_comb begin
      cmd_new.op        = irpw_pkg::op_type'(req_data.operation);
      cmd_new.code_byte = req_data.code_byte;
   end

   assign cmd_port.valid = (count_ff != 2'd0);
   assign cmd_port.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[src/irpw_back.sv]
// ----------------------------------------------------------------------------
// irpw_back
// frame sequencer: one queued word per cycle unless rsp stalls; registers result
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_width_byte_transmitter_assert.svh"

module irpw_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire irpw_pkg::cfg_type      cfg,
   input  wire irpw_pkg::cmd_port_type cmd_port,
   output logic                        cmd_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output irpw_pkg::rsp_word_type      rsp_data
);

   irpw_pkg::phase_type             phase_ff, phase_in;
   logic [irpw_pkg::BITS_W-1:0]     bits_ff, bits_in;
   logic [irpw_pkg::BYTE_W-1:0]     shift_ff, shift_in;
   logic [irpw_pkg::TICK_W-1:0]     ticks_ff, ticks_in;
   logic                            line_ff, line_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   irpw_pkg::rsp_word_type          rsp_data_ff, rsp_data_in;

   logic                            take;
   logic                            busy;
   logic                            done;
   logic                            rej;
   logic [irpw_pkg::TICK_W-1:0]     ticks_dec;
   logic [irpw_pkg::BYTE_W-1:0]     shift_next;

   assign take       = cmd_port.valid & (~rsp_valid_ff | rsp_ready);
   assign cmd_pop    = take;
   assign busy       = (phase_ff != irpw_pkg::PH_IDLE);
   assign ticks_dec  = ticks_ff - irpw_pkg::TICK_W'(1);
   assign shift_next = {shift_ff[irpw_pkg::BYTE_W-2:0], 1'b0};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      phase_in = phase_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      ticks_in = ticks_ff;
      line_in  = line_ff;
      done     = 1'b0;
      rej      = 1'b0;
      if (take) begin
         if (cmd_port.cmd.op == irpw_pkg::OP_SEND) begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               shift_in = cmd_port.cmd.code_byte;
               bits_in  = '0;
               phase_in = irpw_pkg::PH_LEADM;
               ticks_in = irpw_pkg::at_least_one(cfg.lead_mark_ticks);
               line_in  = 1'b1;
            end
         end else if (busy) begin
            ticks_in = ticks_dec;
            if (ticks_dec == '0) begin
               case (phase_ff)
                  irpw_pkg::PH_LEADM: begin
                     phase_in = irpw_pkg::PH_LEADS;
                     ticks_in = irpw_pkg::at_least_one(cfg.lead_space_ticks);
                     line_in  = 1'b0;
                  end
                  irpw_pkg::PH_LEADS: begin
                     bits_in  = bits_ff + irpw_pkg::BITS_W'(1);
                     phase_in = irpw_pkg::PH_BITM;
                     ticks_in = irpw_pkg::at_least_one(
                        shift_ff[irpw_pkg::BYTE_W-1] ? cfg.short_ticks : cfg.long_ticks);
                     line_in  = 1'b1;
                  end
                  irpw_pkg::PH_BITM: begin
                     phase_in = irpw_pkg::PH_BITS;
                     ticks_in = irpw_pkg::at_least_one(
                        shift_ff[irpw_pkg::BYTE_W-1] ? cfg.long_ticks : cfg.short_ticks);
                     line_in  = 1'b0;
                  end
                  irpw_pkg::PH_BITS: begin
                     shift_in = shift_next;
                     if (bits_ff >= irpw_pkg::BITS_W'(irpw_pkg::BITS_PER_FRAME)) begin
                        phase_in = irpw_pkg::PH_STOP;
                        ticks_in = irpw_pkg::at_least_one(cfg.stop_mark_ticks);
                        line_in  = 1'b1;
                     end else begin
                        bits_in  = bits_ff + irpw_pkg::BITS_W'(1);
                        phase_in = irpw_pkg::PH_BITM;
                        ticks_in = irpw_pkg::at_least_one(
                           shift_next[irpw_pkg::BYTE_W-1] ? cfg.short_ticks : cfg.long_ticks);
                        line_in  = 1'b1;
                     end
                  end
                  default: begin
                     // stop mark ends
                     phase_in = irpw_pkg::PH_IDLE;
                     bits_in  = '0;
                     ticks_in = '0;
                     line_in  = 1'b0;
                     done     = 1'b1;
                  end
               endcase
            end
         end
      end

      rsp_data_in.line_level = line_in;
      rsp_data_in.busy_res   = (phase_in != irpw_pkg::PH_IDLE);
      rsp_data_in.frame_done = done;
      rsp_data_in.rejected   = rej;

      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= irpw_pkg::PH_IDLE;
         bits_ff      <= '0;
         shift_ff     <= '0;
         ticks_ff     <= '0;
         line_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         ticks_ff     <= ticks_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `IRPW_ASSERT(a_done_ends_frame, clock, reset, (rsp_valid_ff && rsp_data_ff.frame_done) |-> (!rsp_data_ff.line_level && !rsp_data_ff.busy_res))
   `IRPW_ASSERT(a_reject_only_busy, clock, reset, (rsp_valid_ff && rsp_data_ff.rejected) |-> rsp_data_ff.busy_res)
   `IRPW_ASSERT(a_line_on_marks, clock, reset, line_ff |-> (phase_ff == irpw_pkg::PH_LEADM || phase_ff == irpw_pkg::PH_BITM || phase_ff == irpw_pkg::PH_STOP))
   `IRPW_ASSERT(a_idle_clean, clock, reset, (phase_ff == irpw_pkg::PH_IDLE) |-> (bits_ff == '0 && !line_ff))
   `IRPW_ASSERT_NEVER(a_busy_no_ticks, clock, reset, busy && (ticks_ff == '0))

endmodule

`default_nettype wire

[src/ir_pulse_width_byte_transmitter.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_byte_transmitter
// pulse width coded ir frame sender driven by tick and send words
// ----------------------------------------------------------------------------
// channel  ports                      payload
// req      req_valid / req_ready      req_data  (operation, code_byte)
// rsp      rsp_valid / rsp_ready      rsp_data  (line_level, busy_res,
//                                               frame_done, rejected)
// csr      psel penable pwrite paddr  pwdata / prdata, pready tied high
//
// one word per cycle sustained while rsp_ready is high; a word gives its
// result in the cycle after it leaves the two entry queue, which it enters
// on acceptance. the frame sequencer state update sets that rate. reset
// clears queue, sequencer and result valid flag; durations return to their
// defaults. a stalled rsp channel fills the queue, then drops req_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_byte_transmitter (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire irpw_pkg::req_word_type       req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output irpw_pkg::rsp_word_type            rsp_data,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [irpw_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [irpw_pkg::DATA_W-1:0]  pwdata,
   output logic      [irpw_pkg::DATA_W-1:0]  prdata,
   output logic                              pready
);

   irpw_pkg::cfg_type      cfg;
   irpw_pkg::cmd_port_type cmd_port;
   logic                   cmd_pop;

   irpw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   irpw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_port  (cmd_port),
      .cmd_pop   (cmd_pop)
   );

   irpw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_port  (cmd_port),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[tb/sv/tb_ir_pulse_width_byte_transmitter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_width_byte_transmitter
// drives tick and send words into the ir frame sender and checks every
// result word against a cycle-free model of the frame sequencer; durations
// are reprogrammed between bursts, including zero and full-scale values
// ----------------------------------------------------------------------------

module tb_ir_pulse_width_byte_transmitter;

   localparam int NUM_REGS      = 5;
   localparam int BURST_WORDS   = 240;
   localparam int BURSTS        = 6;
   localparam int REPORT_LIMIT  = 10;

   // frame sequencer model plus the queue of result words still owed
   class irpw_frame_scoreboard;
      logic [irpw_pkg::TICK_W-1:0] dur_by_reg [NUM_REGS];
      irpw_pkg::phase_type         phase;
      logic [irpw_pkg::BITS_W-1:0] bits_sent;
      logic [irpw_pkg::BYTE_W-1:0] shift_byte;
      logic [irpw_pkg::TICK_W-1:0] ticks_left;
      logic                        line;
      irpw_pkg::rsp_word_type      owed_words [$];
      int                          failures;
      int                          words_checked;

      function new();
         dur_by_reg[irpw_pkg::REG_LEAD_MARK]  = irpw_pkg::LEAD_MARK_RESET;
         dur_by_reg[irpw_pkg::REG_LEAD_SPACE] = irpw_pkg::LEAD_SPACE_RESET;
         dur_by_reg[irpw_pkg::REG_SHORT]      = irpw_pkg::SHORT_RESET;
         dur_by_reg[irpw_pkg::REG_LONG]       = irpw_pkg::LONG_RESET;
         dur_by_reg[irpw_pkg::REG_STOP_MARK]  = irpw_pkg::STOP_MARK_RESET;
         phase         = irpw_pkg::PH_IDLE;
         bits_sent     = '0;
         shift_byte    = '0;
         ticks_left    = '0;
         line          = 1'b0;
         failures      = 0;
         words_checked = 0;
      endfunction

      function void write_reg(irpw_pkg::reg_index_type idx,
                              logic [irpw_pkg::TICK_W-1:0] value);
         dur_by_reg[idx] = value;
      endfunction

      function logic [irpw_pkg::TICK_W-1:0] reg_value(irpw_pkg::reg_index_type idx);
         return dur_by_reg[idx];
      endfunction

      function bit busy();
         return phase != irpw_pkg::PH_IDLE;
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("mismatch: %s", msg);
      endfunction

      // zero duration lasts one tick
      function logic [irpw_pkg::TICK_W-1:0] segment_ticks(irpw_pkg::reg_index_type idx);
         return (dur_by_reg[idx] == '0) ? irpw_pkg::TICK_W'(1) : dur_by_reg[idx];
      endfunction

      function void begin_bit_mark();
         bits_sent++;
         phase      = irpw_pkg::PH_BITM;
         ticks_left = segment_ticks(shift_byte[irpw_pkg::BYTE_W-1] ?
                                    irpw_pkg::REG_SHORT : irpw_pkg::REG_LONG);
         line       = 1'b1;
      endfunction

      function void note_input(irpw_pkg::req_word_type w);
         irpw_pkg::rsp_word_type r;
         bit                     was_busy;
         r        = '0;
         was_busy = busy();
         if (irpw_pkg::op_type'(w.operation) == irpw_pkg::OP_SEND) begin
            if (was_busy) begin
               r.rejected = 1'b1;
            end else begin
               shift_byte = w.code_byte;
               bits_sent  = '0;
               phase      = irpw_pkg::PH_LEADM;
               ticks_left = segment_ticks(irpw_pkg::REG_LEAD_MARK);
               line       = 1'b1;
            end
         end else if (was_busy) begin
            ticks_left--;
            if (ticks_left == '0) begin
               case (phase)
                  irpw_pkg::PH_LEADM: begin
                     phase      = irpw_pkg::PH_LEADS;
                     ticks_left = segment_ticks(irpw_pkg::REG_LEAD_SPACE);
                     line       = 1'b0;
                  end
                  irpw_pkg::PH_LEADS: begin
                     begin_bit_mark();
                  end
                  irpw_pkg::PH_BITM: begin
                     phase      = irpw_pkg::PH_BITS;
                     ticks_left = segment_ticks(shift_byte[irpw_pkg::BYTE_W-1] ?
                                                irpw_pkg::REG_LONG : irpw_pkg::REG_SHORT);
                     line       = 1'b0;
                  end
                  irpw_pkg::PH_BITS: begin
                     shift_byte = shift_byte << 1;
                     if (bits_sent >= irpw_pkg::BITS_PER_FRAME) begin
                        phase      = irpw_pkg::PH_STOP;
                        ticks_left = segment_ticks(irpw_pkg::REG_STOP_MARK);
                        line       = 1'b1;
                     end else begin
                        begin_bit_mark();
                     end
                  end
                  default: begin
                     // stop mark over, frame complete
                     phase        = irpw_pkg::PH_IDLE;
                     bits_sent    = '0;
                     ticks_left   = '0;
                     line         = 1'b0;
                     r.frame_done = 1'b1;
                  end
               endcase
            end
         end
         r.line_level = line;
         r.busy_res   = busy();
         owed_words.push_back(r);
      endfunction

      function void check_result(irpw_pkg::rsp_word_type got);
         irpw_pkg::rsp_word_type want;
         if (owed_words.size() == 0) begin
            note_failure($sformatf("result word %b with nothing outstanding", got));
            return;
         end
         want = owed_words.pop_front();
         if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
             got.frame_done !== want.frame_done || got.rejected !== want.rejected) begin
            note_failure($sformatf(
               "word %0d expected line %b busy %b done %b rej %b, got %b %b %b %b",
               words_checked, want.line_level, want.busy_res, want.frame_done,
               want.rejected, got.line_level, got.busy_res, got.frame_done, got.rejected));
         end
         words_checked++;
      endfunction
   endclass

   logic                          clock;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   irpw_pkg::req_word_type        req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   irpw_pkg::rsp_word_type        rsp_data;
   logic                          psel      = 1'b0;
   logic                          penable   = 1'b0;
   logic                          pwrite    = 1'b0;
   logic [irpw_pkg::ADDR_W-1:0]   paddr     = '0;
   logic [irpw_pkg::DATA_W-1:0]   pwdata    = '0;
   logic [irpw_pkg::DATA_W-1:0]   prdata;
   logic                          pready;

   int                  req_idle_pct = 0;
   int                  rsp_idle_pct = 0;
   irpw_frame_scoreboard sb = new();

   ir_pulse_width_byte_transmitter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // one word through the req channel, with a random gap after it
   task automatic put_word(input irpw_pkg::req_word_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(w);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   task automatic put_op(input irpw_pkg::op_type op,
                         input logic [irpw_pkg::BYTE_W-1:0] code);
      irpw_pkg::req_word_type w;
      w.operation = op;
      w.code_byte = code;
      put_word(w);
   endtask

   // mostly ticks while a frame runs, a few sends that must bounce
   function automatic irpw_pkg::req_word_type random_word(bit busy_now);
      irpw_pkg::req_word_type w;
      int                     roll;
      roll        = $urandom_range(99);
      w.code_byte = irpw_pkg::BYTE_W'($urandom);
      if (busy_now) w.operation = (roll < 4) ? irpw_pkg::OP_SEND : irpw_pkg::OP_TICK;
      else          w.operation = (roll < 35) ? irpw_pkg::OP_SEND : irpw_pkg::OP_TICK;
      return w;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input irpw_pkg::reg_index_type idx, input bit is_write,
                             input logic [irpw_pkg::DATA_W-1:0] wdata,
                             output logic [irpw_pkg::DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata    = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input irpw_pkg::reg_index_type idx);
      logic [irpw_pkg::DATA_W-1:0] got;
      csr_access(idx, 1'b0, '0, got);
      if (got !== irpw_pkg::DATA_W'(sb.reg_value(idx)))
         sb.note_failure($sformatf("register %s read %h, expected %h",
                                   idx.name(), got, sb.reg_value(idx)));
   endtask

   // upper data bits are junk that the register must drop
   task automatic csr_set(input irpw_pkg::reg_index_type idx,
                          input logic [irpw_pkg::TICK_W-1:0] value);
      logic [irpw_pkg::DATA_W-1:0] unused;
      csr_access(idx, 1'b1, {16'($urandom), value}, unused);
      sb.write_reg(idx, value);
      csr_check(idx);
   endtask

   function automatic logic [irpw_pkg::TICK_W-1:0] pick_duration();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return irpw_pkg::TICK_W'($urandom_range(0, 3));
      if (roll < 90) return irpw_pkg::TICK_W'($urandom_range(4, 9));
      return irpw_pkg::TICK_W'($urandom_range(10, 30));
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_REGS; i++) csr_check(irpw_pkg::reg_index_type'(i));

      // directed: every segment one tick long
      req_idle_pct = 27;
      rsp_idle_pct = 49;
      for (int i = 0; i < NUM_REGS; i++) csr_set(irpw_pkg::reg_index_type'(i), '0);
      put_op(irpw_pkg::OP_TICK, 8'hFF);
      put_op(irpw_pkg::OP_SEND, 8'hA5);
      put_op(irpw_pkg::OP_SEND, 8'h3C);
      repeat (19) put_op(irpw_pkg::OP_TICK, 8'h00);
      put_op(irpw_pkg::OP_TICK, 8'h5A);
      put_op(irpw_pkg::OP_SEND, 8'h00);
      put_op(irpw_pkg::OP_TICK, 8'hFF);

      for (int b = 0; b < BURSTS; b++) begin
         wait_drained();
         case (b / 2)
            0:       begin req_idle_pct = 27; rsp_idle_pct = 49; end
            1:       begin req_idle_pct = 49; rsp_idle_pct = 27; end
            default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         if (b == BURSTS - 1) begin
            for (int i = 0; i < NUM_REGS; i++) csr_set(irpw_pkg::reg_index_type'(i), '1);
         end
         for (int i = 0; i < NUM_REGS; i++)
            csr_set(irpw_pkg::reg_index_type'(i), pick_duration());
         // last burst holds one full-scale lead mark to the end
         if (b == BURSTS - 1) csr_set(irpw_pkg::REG_LEAD_MARK, '1);
         repeat (BURST_WORDS) put_word(random_word(sb.busy()));
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
